/* rtl/omd_pkg.sv */
`default_nettype none
package omd_pkg;

   // sine fraction bits and derived widths
   localparam int SINE_FRAC_BITS = 14;
   localparam int SHIFT_SINE     = 16 - SINE_FRAC_BITS;
   localparam int SMAG_W         = SINE_FRAC_BITS + 1;
   localparam int POW_W          = 7;
   localparam int QW             = POW_W + SINE_FRAC_BITS;
   localparam int NUM_W          = SMAG_W + POW_W;
   localparam int REM_W          = SINE_FRAC_BITS + 2;
   localparam int WW             = SINE_FRAC_BITS + 18;
   localparam int CNT_W          = $clog2(QW);
   localparam int GAIN_W         = 12;

   // register indexes
   localparam logic [1:0] REG_GYRO_KP = 2'd0;
   localparam logic [1:0] REG_GYRO_KD = 2'd1;
   localparam logic [1:0] REG_GOAL_KP = 2'd2;
   localparam logic [1:0] REG_GOAL_KD = 2'd3;

   // quarter-wave sine, round(sin(k deg) * 65536)
   localparam logic [16:0] QSINE [0:90] = '{
      17'd0, 17'd1144, 17'd2287, 17'd3430, 17'd4572, 17'd5712, 17'd6850, 17'd7987,
      17'd9121, 17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742, 17'd15855,
      17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415, 17'd23486,
      17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753, 17'd30767,
      17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647, 17'd37590,
      17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995, 17'd43852,
      17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703, 17'd49461,
      17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684, 17'd54332,
      17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865, 17'd58393,
      17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183, 17'd61584,
      17'd61965, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589, 17'd63856,
      17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65047, 17'd65177,
      17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
   };

   // wheel angle offsets
   localparam logic [9:0] WHEEL_OFS [0:3] = '{10'd50, 10'd310, 10'd130, 10'd230};

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_PD_MUL, OP_PD_ACC, OP_SINE, OP_MUL, OP_DINIT,
      OP_DSTEP, OP_DSTORE, OP_MIX, OP_MAX, OP_ADJ, OP_FIN
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

   typedef struct packed {
      logic              neg;
      logic [SMAG_W-1:0] mag;
   } sine_type;

   // signed sine of an angle up to 1023 degrees
   function automatic sine_type sine_q(input logic [9:0] ang);
      logic [9:0]  a;
      logic [6:0]  qi;
      logic [16:0] v;
      sine_type    s;
      a = ang;
      if (a >= 10'd720) a = a - 10'd720;
      else if (a >= 10'd360) a = a - 10'd360;
      s.neg = 1'b0;
      if (a >= 10'd180) begin
         a = a - 10'd180;
         s.neg = 1'b1;
      end
      qi = (a <= 10'd90) ? a[6:0] : 7'(10'd180 - a);
      v = QSINE[qi];
      v = (v + 17'((1 << SHIFT_SINE) >> 1)) >> SHIFT_SINE;
      s.mag = v[SMAG_W-1:0];
      return s;
   endfunction

endpackage
`default_nettype wire

/* rtl/omni_drive_mixer_pd_heading.sv */
// items are handled one at a time: a new input word is taken only after the previous
// item has handed its result to the output register; the shared restoring divider
//   works out 21 quotient bits per wheel, four wheels in turn
// a finished result waits in the output register while the next item runs
// reset: synchronous, restores default gains and clears the previous error
`default_nettype none
module omni_drive_mixer_pd_heading import omd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // heading_deg, direction_deg, drive_power
   input  wire logic [0:0]  req_tuser,  // use_goal_gains
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // wheel_a, wheel_b, wheel_c, wheel_d
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [11:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   // sequencer
   omd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // arithmetic and registers
   omd_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .in_goal      (req_tuser[0]),
      .in_heading   (req_tdata[8:0]),
      .in_direction (req_tdata[17:9]),
      .in_power     (req_tdata[24:18]),
      .csr_we       (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule
`default_nettype wire

/* rtl/omd_ctrl.sv */
`default_nettype none
module omd_ctrl import omd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   input  stat_type  stat,
   output cmd_type   cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_PD_MUL, S_PD_ACC, S_SINE, S_MUL, S_DINIT, S_DSTEP, S_DSTORE,
      S_MIX, S_MAX, S_ADJ, S_FIN
   } state_type;

   state_type        state_ff;
   logic [1:0]       idx_ff;
   logic [CNT_W-1:0] cnt_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= 2'd0;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_tvalid) state_ff <= S_PD_MUL;
            S_PD_MUL: state_ff <= S_PD_ACC;
            S_PD_ACC: begin
               state_ff <= S_SINE;
               idx_ff   <= 2'd0;
            end
            S_SINE: begin
               idx_ff <= idx_ff + 2'd1;
               if (idx_ff == 2'd3) state_ff <= S_MUL;
            end
            S_MUL: state_ff <= S_DINIT;
            S_DINIT: begin
               state_ff <= S_DSTEP;
               cnt_ff   <= CNT_W'(QW - 1);
            end
            S_DSTEP: begin
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (cnt_ff == '0) state_ff <= S_DSTORE;
            end
            S_DSTORE: begin
               idx_ff   <= idx_ff + 2'd1;
               state_ff <= (idx_ff == 2'd3) ? S_MIX : S_MUL;
            end
            S_MIX: state_ff <= S_MAX;
            S_MAX: state_ff <= S_ADJ;
            S_ADJ: state_ff <= S_FIN;
            S_FIN: if (stat.out_free) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // command decode
   always_comb begin
      cmd.idx = idx_ff;
      unique case (state_ff)
         S_IDLE:   cmd.op = req_tvalid ? OP_LOAD : OP_NONE;
         S_PD_MUL: cmd.op = OP_PD_MUL;
         S_PD_ACC: cmd.op = OP_PD_ACC;
         S_SINE:   cmd.op = OP_SINE;
         S_MUL:    cmd.op = OP_MUL;
         S_DINIT:  cmd.op = OP_DINIT;
         S_DSTEP:  cmd.op = OP_DSTEP;
         S_DSTORE: cmd.op = OP_DSTORE;
         S_MIX:    cmd.op = OP_MIX;
         S_MAX:    cmd.op = OP_MAX;
         S_ADJ:    cmd.op = OP_ADJ;
         S_FIN:    cmd.op = stat.out_free ? OP_FIN : OP_NONE;
         default:  cmd.op = OP_NONE;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while item in progress");
   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && !stat.out_free) |=> state_ff == S_FIN)
      else $error("result dropped while output full");
   a_last_wheel: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DSTORE && idx_ff == 2'd3) |=> state_ff == S_MIX)
      else $error("wheel sequence broken");

endmodule
`default_nettype wire

/* rtl/omd_dp.sv */
`default_nettype none
module omd_dp import omd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  wire logic              in_goal,
   input  wire logic [8:0]        in_heading,
   input  wire logic [8:0]        in_direction,
   input  wire logic [POW_W-1:0]  in_power,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [GAIN_W-1:0] csr_data,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [31:0]            rsp_tdata
);

   logic [GAIN_W-1:0]        gyro_kp_ff, gyro_kd_ff, goal_kp_ff, goal_kd_ff;
   logic                     goal_ff;
   logic signed [8:0]        err_ff, prev_ff;
   logic [8:0]               dir_ff;
   logic [POW_W-1:0]         pow_ff;
   logic signed [21:0]       pprod_ff;
   logic signed [15:0]       pd_ff;
   logic [SMAG_W-1:0]        smag_ff [0:3];
   logic [3:0]               sneg_ff;
   logic [SMAG_W-1:0]        m_ff;
   logic [NUM_W-1:0]         num_ff;
   logic [REM_W-1:0]         rem_ff;
   logic [QW-1:0]            dvd_ff;
   logic signed [WW-1:0]     w_ff [0:3];
   logic [WW-1:0]            top_ff;
   logic                     rsp_tvalid_ff;
   logic [31:0]              rsp_tdata_ff;

   logic signed [9:0]        hd_ext, err_wrap;
   logic [GAIN_W-1:0]        kp_sel, kd_sel;
   logic signed [21:0]       pprod_c;
   logic signed [9:0]        ediff;
   logic signed [22:0]       dprod_c;
   logic signed [23:0]       acc_c;
   logic [23:0]              acc_mag;
   logic [15:0]              acc_sh;
   sine_type                 sine_c;
   logic [NUM_W+SINE_FRAC_BITS-1:0] full_c;
   logic [REM_W-1:0]         trial_c;
   logic                     qbit_c;
   logic signed [WW-1:0]     q_ext, pds_c;
   logic [WW-1:0]            mag_c [0:3];
   logic [WW-1:0]            max01_c, max23_c;
   logic [WW-1:0]            diff_c;
   logic [7:0]               r_c [0:3];

   // gain registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gyro_kp_ff <= 12'd307;
         gyro_kd_ff <= 12'd870;
         goal_kp_ff <= 12'd128;
         goal_kd_ff <= 12'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_GYRO_KP: gyro_kp_ff <= csr_data;
            REG_GYRO_KD: gyro_kd_ff <= csr_data;
            REG_GOAL_KP: goal_kp_ff <= csr_data;
            REG_GOAL_KD: goal_kd_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // heading wrap and pd terms
   always_comb begin
      hd_ext   = signed'({1'b0, in_heading});
      err_wrap = (in_heading > 9'd180) ? hd_ext - 10'sd360 : hd_ext;
      kp_sel   = goal_ff ? goal_kp_ff : gyro_kp_ff;
      kd_sel   = goal_ff ? goal_kd_ff : gyro_kd_ff;
      pprod_c  = err_ff * signed'({1'b0, kp_sel});
      ediff    = 10'(err_ff) - 10'(prev_ff);
      dprod_c  = ediff * signed'({1'b0, kd_sel});
      acc_c    = 24'(pprod_ff) + 24'(dprod_c);
      acc_mag  = acc_c[23] ? 24'(-acc_c) : 24'(acc_c);
      acc_sh   = 16'(acc_mag >> 8);
   end

   // wheel sine and divider step
   always_comb begin
      sine_c  = sine_q(10'(dir_ff) + WHEEL_OFS[cmd.idx]);
      full_c  = {num_ff, {SINE_FRAC_BITS{1'b0}}};
      trial_c = {rem_ff[REM_W-2:0], dvd_ff[QW-1]};
      qbit_c  = (trial_c >= REM_W'(m_ff));
      q_ext   = signed'(WW'(dvd_ff));
      pds_c   = WW'(pd_ff) <<< SINE_FRAC_BITS;
   end

   // magnitudes, peak and excess
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mag_c[i] = w_ff[i][WW-1] ? WW'(-w_ff[i]) : WW'(w_ff[i]);
      end
      max01_c = (mag_c[0] > mag_c[1]) ? mag_c[0] : mag_c[1];
      max23_c = (mag_c[2] > mag_c[3]) ? mag_c[2] : mag_c[3];
      diff_c  = ((top_ff >> SINE_FRAC_BITS) - WW'(100)) << SINE_FRAC_BITS;
   end

   // final truncation, clamp and output sign
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         logic [WW-1:0] rm;
         logic [7:0]    rs;
         rm = mag_c[i] >> SINE_FRAC_BITS;
         rs = (rm > WW'(100)) ? 8'd100 : rm[7:0];
         if (w_ff[i][WW-1] ^ (i >= 2)) r_c[i] = 8'(-rs);
         else r_c[i] = rs;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         unique case (cmd.op)
            OP_LOAD: begin
               goal_ff <= in_goal;
               err_ff  <= err_wrap[8:0];
               dir_ff  <= in_direction;
               pow_ff  <= in_power;
               m_ff    <= '0;
            end
            OP_PD_MUL: pprod_ff <= pprod_c;
            OP_PD_ACC: begin
               pd_ff   <= acc_c[23] ? 16'(-signed'(acc_sh)) : signed'(acc_sh);
               prev_ff <= err_ff;
            end
            OP_SINE: begin
               smag_ff[cmd.idx] <= sine_c.mag;
               sneg_ff[cmd.idx] <= sine_c.neg;
               if (sine_c.mag > m_ff) m_ff <= sine_c.mag;
            end
            OP_MUL: num_ff <= NUM_W'(smag_ff[cmd.idx] * pow_ff);
            OP_DINIT: begin
               rem_ff <= REM_W'(full_c >> QW);
               dvd_ff <= full_c[QW-1:0];
            end
            OP_DSTEP: begin
               rem_ff <= qbit_c ? trial_c - REM_W'(m_ff) : trial_c;
               dvd_ff <= {dvd_ff[QW-2:0], qbit_c};
            end
            OP_DSTORE: w_ff[cmd.idx] <= sneg_ff[cmd.idx] ? q_ext : -q_ext;
            OP_MIX: begin
               w_ff[0] <= w_ff[0] - pds_c;
               w_ff[1] <= w_ff[1] + pds_c;
               w_ff[2] <= w_ff[2] + pds_c;
               w_ff[3] <= w_ff[3] - pds_c;
            end
            OP_MAX: top_ff <= (max01_c > max23_c) ? max01_c : max23_c;
            OP_ADJ: begin
               if (top_ff > (WW'(100) << SINE_FRAC_BITS)) begin
                  for (int i = 0; i < 4; i++) begin
                     w_ff[i] <= (w_ff[i] > 0) ? w_ff[i] - signed'(diff_c)
                                              : w_ff[i] + signed'(diff_c);
                  end
               end
            end
            OP_FIN: rsp_tdata_ff <= {r_c[3], r_c[2], r_c[1], r_c[0]};
            default: ;
         endcase
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.op == OP_FIN) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid    = rsp_tvalid_ff;
   assign rsp_tdata     = rsp_tdata_ff;
   assign stat.out_free = !rsp_tvalid_ff || rsp_tready;

   a_fin_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FIN) |=> rsp_tvalid_ff)
      else $error("result word not presented");
   a_fin_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FIN) |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("result word overwritten");
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_DINIT) |-> (m_ff != '0))
      else $error("zero divisor in wheel scaling");

endmodule
`default_nettype wire

/* sim/tb_omni_drive_mixer_pd_heading.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_omni_drive_mixer_pd_heading;
   import omd_pkg::*;

   typedef struct {
      logic       use_goal;
      logic [8:0] heading;
      logic [8:0] direction;
      logic [6:0] power;
   } drive_cmd_type;

   typedef struct {
      logic signed [7:0] w [4];
   } wheel_set_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [11:0] csr_data = '0;

   drive_cmd_type cmd_queue [$];
   wheel_set_type wheel_queue [$];
   drive_cmd_type cur_cmd;

   // model copy of gains and heading memory
   logic [11:0] m_gyro_kp, m_gyro_kd, m_goal_kp, m_goal_kd;
   int          m_prev_err;
   int          idle_mode = 0;
   int          errors = 0;
   int          quiet_cycles = 0;

   always #1 clock = ~clock;

   omni_drive_mixer_pd_heading DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // signed sine with SINE_FRAC_BITS fraction bits
   function automatic longint sine_fixed(input int angle);
      int     a;
      int     idx;
      bit     neg;
      longint v;
      a = angle % 360;
      neg = 1'b0;
      if (a >= 180) begin
         a = a - 180;
         neg = 1'b1;
      end
      idx = (a <= 90) ? a : 180 - a;
      v = longint'(QSINE[idx]);
      if (SINE_FRAC_BITS < 16) v = (v + (64'sd1 << (15 - SINE_FRAC_BITS))) >>> (16 - SINE_FRAC_BITS);
      return neg ? -v : v;
   endfunction

   function automatic longint shift_toward_zero(input longint v, input int sh);
      if (v >= 0) return v >>> sh;
      return -((-v) >>> sh);
   endfunction

   function automatic longint abs64(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // wheel mix for one command; advances the heading memory
   function automatic wheel_set_type mix_wheels(input drive_cmd_type c);
      wheel_set_type r;
      longint     w [4];
      longint     one, pd, top, diff, kp, kd, pw, q;
      int         err;
      int         ofs [4];
      ofs = '{50, 310, 130, 230};
      one = 64'sd1 << SINE_FRAC_BITS;
      kp = c.use_goal ? m_goal_kp : m_gyro_kp;
      kd = c.use_goal ? m_goal_kd : m_gyro_kd;
      pw = c.power;
      err = c.heading;
      if (err > 180) err = err - 360;
      pd = shift_toward_zero(err * kp + (err - m_prev_err) * kd, 8);
      m_prev_err = err;
      top = 0;
      for (int i = 0; i < 4; i++) begin
         w[i] = -pw * sine_fixed(int'(c.direction) + ofs[i]);
         if (abs64(w[i]) > top) top = abs64(w[i]);
      end
      if (top != 0)
         for (int i = 0; i < 4; i++) w[i] = (w[i] * pw * one) / top;
      w[0] -= pd * one;
      w[1] += pd * one;
      w[2] += pd * one;
      w[3] -= pd * one;
      top = 0;
      for (int i = 0; i < 4; i++) if (abs64(w[i]) > top) top = abs64(w[i]);
      // spread the excess over all wheels
      if (top > 100 * one) begin
         diff = ((top >>> SINE_FRAC_BITS) - 100) * one;
         for (int i = 0; i < 4; i++) w[i] = (w[i] > 0) ? w[i] - diff : w[i] + diff;
      end
      for (int i = 0; i < 4; i++) begin
         q = shift_toward_zero(w[i], SINE_FRAC_BITS);
         if (q > 100) q = 100;
         if (q < -100) q = -100;
         if (i >= 2) q = -q;
         r.w[i] = 8'(q);
      end
      return r;
   endfunction

   function automatic bit idle_now(input bit sender);
      int pct;
      if (idle_mode == 2) return 1'b0;
      pct = ((idle_mode == 0) == sender) ? 30 : 64;
      return $urandom_range(99) < pct;
   endfunction

   // input driver: predicts on every accepted word
   always @(posedge clock) begin
      drive_cmd_type nxt;
      logic          nv;
      nv = req_tvalid;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            wheel_queue.push_back(mix_wheels(cur_cmd));
            nv = 1'b0;
         end
         if (!nv && cmd_queue.size() > 0 && !idle_now(1'b1)) begin
            nxt = cmd_queue.pop_front();
            cur_cmd = nxt;
            nv = 1'b1;
            req_tdata <= {7'b0, nxt.power, nxt.direction, nxt.heading};
            req_tuser <= nxt.use_goal;
         end
      end
      req_tvalid <= nv;
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      wheel_set_type e;
      logic signed [7:0] got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (wheel_queue.size() == 0) begin
            $display("%0t: unexpected word actual=%h", $realtime, rsp_tdata);
            errors++;
         end else begin
            e = wheel_queue.pop_front();
            for (int i = 0; i < 4; i++) begin
               got = rsp_tdata[8*i +: 8];
               if (got !== e.w[i]) begin
                  $display("%0t: wheel %0d expected=%0d actual=%0d",
                           $realtime, i, e.w[i], got);
                  errors++;
               end
            end
         end
      end
      rsp_tready <= reset ? 1'b0 : !idle_now(1'b0);
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_gain(input logic [1:0] idx, input logic [11:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_GYRO_KP: m_gyro_kp = val;
         REG_GYRO_KD: m_gyro_kd = val;
         REG_GOAL_KP: m_goal_kp = val;
         REG_GOAL_KD: m_goal_kd = val;
      endcase
   endtask

   task automatic add_cmd(input logic g, input int h, input int d, input int p);
      drive_cmd_type c;
      c.use_goal = g;
      c.heading = 9'(h);
      c.direction = 9'(d);
      c.power = 7'(p);
      cmd_queue.push_back(c);
   endtask

   task automatic add_random(input int n);
      for (int i = 0; i < n; i++)
         add_cmd($urandom_range(1),
                 ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(359),
                 ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(359),
                 ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(100));
   endtask

   // sample queues and handshakes away from the driving edge
   task automatic drain();
      while (cmd_queue.size() > 0 || req_tvalid || wheel_queue.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      m_gyro_kp = 12'd307;
      m_gyro_kd = 12'd870;
      m_goal_kp = 12'd128;
      m_goal_kd = 12'd256;
      m_prev_err = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: heading wrap, direction wrap, zero and over-range power
      add_cmd(0, 0, 0, 0);
      add_cmd(0, 180, 0, 100);
      add_cmd(0, 181, 90, 100);
      add_cmd(1, 359, 359, 100);
      add_cmd(1, 360, 360, 50);
      add_cmd(0, 511, 511, 127);
      add_cmd(1, 0, 45, 127);
      add_cmd(0, 90, 180, 1);
      add_cmd(0, 270, 270, 100);
      add_cmd(1, 180, 135, 0);
      add_cmd(0, 0, 0, 100);
      add_cmd(1, 1, 500, 64);
      add_cmd(0, 256, 256, 127);
      add_cmd(1, 511, 1, 100);
      add_random(100);
      drain();

      write_gain(REG_GYRO_KP, 12'hFFF);
      write_gain(REG_GYRO_KD, 12'hFFF);
      write_gain(REG_GOAL_KP, 12'hFFF);
      write_gain(REG_GOAL_KD, 12'hFFF);
      add_cmd(0, 180, 0, 100);
      add_cmd(1, 181, 90, 127);
      add_random(150);
      drain();

      idle_mode = 1;
      write_gain(REG_GYRO_KP, 12'd0);
      write_gain(REG_GYRO_KD, 12'd0);
      write_gain(REG_GOAL_KP, 12'd0);
      write_gain(REG_GOAL_KD, 12'd0);
      add_random(170);
      drain();

      idle_mode = 2;
      write_gain(REG_GYRO_KP, 12'($urandom_range(4095)));
      write_gain(REG_GYRO_KD, 12'($urandom_range(4095)));
      write_gain(REG_GOAL_KP, 12'($urandom_range(4095)));
      write_gain(REG_GOAL_KD, 12'($urandom_range(4095)));
      add_random(170);
      drain();

      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
`default_nettype wire
